@@ hw/rtl/tcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// tcfp_pkg
// Shared constants and the frame record type of the telemetry command parser.
// ----------------------------------------------------------------------------
package tcfp_pkg;

  localparam logic [7:0] CFG_MARK    = 8'h55;
  localparam logic [7:0] DOUT_MARK_A = 8'hAA;
  localparam logic [7:0] DOUT_MARK_B = 8'h4F;

  localparam int unsigned CFG_LEN   = 15;
  localparam int unsigned CFG_CNT_W = $clog2(CFG_LEN + 1);
  localparam int unsigned SUM_W     = 16;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic KIND_CONFIG = 1'b0;
  localparam logic KIND_DOUT   = 1'b1;

  typedef struct packed {
    logic        frame_kind;
    logic [1:0]  accel_gyro_rate;
    logic [3:0]  analog_power;
    logic [7:0]  analog_rate;
    logic [31:0] daq_power_nibbles;
    logic [31:0] daq_types_low;
    logic [31:0] daq_types_high;
    logic [7:0]  dout_power;
    logic [7:0]  dout_state;
    logic        checksum_ok;
    logic        first_config;
  } frame_rec_t;

endpackage

@@ hw/rtl/telemetry_command_frame_parser.sv @@
// ----------------------------------------------------------------------------
// telemetry_command_frame_parser
// Parses configuration and digital-output command frames from a byte stream.
// ----------------------------------------------------------------------------
// takes one received byte per clock while in_stall is low; the parser decides
// each byte in the cycle it is taken, so a byte stream runs at one word per
// cycle. a good frame lands in a short record queue on its last byte and then
// in the result register. in_stall rises only when the record queue is full,
// which happens only while out_stall holds results back. a configuration
// frame is 0x55 0x55, fifteen data bytes and a big-endian 16-bit sum; a
// digital-output frame is two marks of 0xaa or 0x4f, a power byte and a state
// byte. with checksum checking enabled, configuration frames whose sum does
// not match are dropped. cfg_ready is always high.
module telemetry_command_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = tcfp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_kind,
  output logic [1:0]  out_accel_gyro_rate,
  output logic [3:0]  out_analog_power,
  output logic [7:0]  out_analog_rate,
  output logic [31:0] out_daq_power_nibbles,
  output logic [31:0] out_daq_types_low,
  output logic [31:0] out_daq_types_high,
  output logic [7:0]  out_dout_power,
  output logic [7:0]  out_dout_state,
  output logic        out_checksum_ok,
  output logic        out_first_config,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_checksum_check_enable
);

  logic                 check_enable_r;
  logic                 q_full;
  logic                 q_not_empty;
  logic                 q_pop;
  logic                 push;
  tcfp_pkg::frame_rec_t push_rec;
  tcfp_pkg::frame_rec_t head_rec;
  tcfp_pkg::frame_rec_t out_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_enable_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      check_enable_r <= cfg_checksum_check_enable;
    end
  end

  tcfp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_rx_byte   (in_rx_byte),
    .q_full       (q_full),
    .check_enable (check_enable_r),
    .in_stall     (in_stall),
    .push         (push),
    .push_rec     (push_rec)
  );

  tcfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  tcfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head_rec  (head_rec),
    .out_stall   (out_stall),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_rec     (out_rec)
  );

  assign out_frame_kind        = out_rec.frame_kind;
  assign out_accel_gyro_rate   = out_rec.accel_gyro_rate;
  assign out_analog_power      = out_rec.analog_power;
  assign out_analog_rate       = out_rec.analog_rate;
  assign out_daq_power_nibbles = out_rec.daq_power_nibbles;
  assign out_daq_types_low     = out_rec.daq_types_low;
  assign out_daq_types_high    = out_rec.daq_types_high;
  assign out_dout_power        = out_rec.dout_power;
  assign out_dout_state        = out_rec.dout_state;
  assign out_checksum_ok       = out_rec.checksum_ok;
  assign out_first_config      = out_rec.first_config;

endmodule

@@ hw/rtl/tcfp_front.sv @@
// ----------------------------------------------------------------------------
// tcfp_front
// Byte parser: tracks framing, stores configuration data, keeps the running
// sum and emits one frame record per good frame.
// ----------------------------------------------------------------------------
module tcfp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_rx_byte,
  input  logic                q_full,
  input  logic                check_enable,
  output logic                in_stall,
  output logic                push,
  output tcfp_pkg::frame_rec_t push_rec
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CFG_PRE2,
    PH_CFG_DATA,
    PH_CFG_CKH,
    PH_CFG_CKL,
    PH_DO_PRE2,
    PH_DO_PWR,
    PH_DO_ST
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic [tcfp_pkg::CFG_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [tcfp_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [7:0]                       data_r [tcfp_pkg::CFG_LEN];
  logic [7:0]                       ck_high_r;
  logic [7:0]                       pwr_hold_r;
  logic                             seen_r, seen_nxt;
  logic                             accept;
  logic                             is_dout;
  logic                             sum_ok;
  logic                             data_wr;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_dout  = (in_rx_byte == tcfp_pkg::DOUT_MARK_A) ||
                    (in_rx_byte == tcfp_pkg::DOUT_MARK_B);
  assign sum_ok   = ({ck_high_r, in_rx_byte} == sum_r);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    seen_nxt  = seen_r;
    data_wr   = 1'b0;
    push      = 1'b0;
    push_rec  = '0;
    if (accept) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_rx_byte == tcfp_pkg::CFG_MARK) begin
            phase_nxt = PH_CFG_PRE2;
          end else if (is_dout) begin
            phase_nxt = PH_DO_PRE2;
          end
        end
        PH_CFG_PRE2: begin
          if (in_rx_byte == tcfp_pkg::CFG_MARK) begin
            phase_nxt = PH_CFG_DATA;
            cnt_nxt   = '0;
            sum_nxt   = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_CFG_DATA: begin
          data_wr = 1'b1;
          sum_nxt = sum_r + tcfp_pkg::SUM_W'(in_rx_byte);
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == tcfp_pkg::CFG_CNT_W'(tcfp_pkg::CFG_LEN - 1)) begin
            phase_nxt = PH_CFG_CKH;
          end
        end
        PH_CFG_CKH: begin
          phase_nxt = PH_CFG_CKL;
        end
        PH_CFG_CKL: begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
          if (!check_enable || sum_ok) begin
            push                       = 1'b1;
            push_rec.frame_kind        = tcfp_pkg::KIND_CONFIG;
            push_rec.accel_gyro_rate   = data_r[0][1:0];
            push_rec.analog_power      = data_r[1][3:0];
            push_rec.analog_rate       = data_r[2];
            push_rec.daq_power_nibbles = {data_r[6], data_r[5], data_r[4], data_r[3]};
            push_rec.daq_types_low     = {data_r[10], data_r[9], data_r[8], data_r[7]};
            push_rec.daq_types_high    = {data_r[14], data_r[13], data_r[12], data_r[11]};
            push_rec.checksum_ok       = sum_ok;
            push_rec.first_config      = !seen_r;
            seen_nxt                   = 1'b1;
          end
        end
        PH_DO_PRE2: begin
          phase_nxt = is_dout ? PH_DO_PWR : PH_IDLE;
        end
        PH_DO_PWR: begin
          phase_nxt = PH_DO_ST;
        end
        PH_DO_ST: begin
          phase_nxt           = PH_IDLE;
          push                = 1'b1;
          push_rec.frame_kind = tcfp_pkg::KIND_DOUT;
          push_rec.dout_power = pwr_hold_r;
          push_rec.dout_state = in_rx_byte;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      seen_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (data_wr) begin
      data_r[cnt_r] <= in_rx_byte;
    end
    if (accept && (phase_r == PH_CFG_CKH)) begin
      ck_high_r <= in_rx_byte;
    end
    if (accept && (phase_r == PH_DO_PWR)) begin
      pwr_hold_r <= in_rx_byte;
    end
  end

endmodule

@@ hw/rtl/tcfp_queue.sv @@
// ----------------------------------------------------------------------------
// tcfp_queue
// Short first-in first-out queue of frame records between parser and output.
// ----------------------------------------------------------------------------
module tcfp_queue #(
  parameter int unsigned DEPTH = tcfp_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tcfp_pkg::frame_rec_t push_rec,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output tcfp_pkg::frame_rec_t head_rec
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tcfp_pkg::frame_rec_t entry_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_rec  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

@@ hw/rtl/tcfp_back.sv @@
// ----------------------------------------------------------------------------
// tcfp_back
// Output stage: moves frame records from the queue into the result register
// and holds them until the downstream side takes the word.
// ----------------------------------------------------------------------------
module tcfp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  tcfp_pkg::frame_rec_t q_head_rec,
  input  logic                 out_stall,
  output logic                 q_pop,
  output logic                 out_valid,
  output tcfp_pkg::frame_rec_t out_rec
);

  logic                 valid_r;
  tcfp_pkg::frame_rec_t rec_r;

  assign q_pop     = q_not_empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_rec   = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= q_head_rec;
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression bench for the telemetry command frame parser: drives directed and
// random byte streams with random gaps and back-pressure, predicts each decoded
// frame and checks every result field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_BYTES  = 625;
  localparam int MAX_GAP       = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CFG_MARK2,
    ST_CFG_DATA,
    ST_CFG_SUM_HI,
    ST_CFG_SUM_LO,
    ST_DOUT_MARK2,
    ST_DOUT_POWER,
    ST_DOUT_STATE
  } parse_state_t;

  typedef logic [7:0] cfg_block_t [tcfp_pkg::CFG_LEN];

  class command_frame_scoreboard_t;
    parse_state_t         phase;
    int unsigned          data_count;
    logic [7:0]           cfg_bytes [tcfp_pkg::CFG_LEN];
    logic [15:0]          running_sum;
    logic [7:0]           sum_high;
    logic [7:0]           power_hold;
    bit                   config_seen;
    bit                   check_en;
    tcfp_pkg::frame_rec_t decoded_frames [$];
    int                   errors;

    function new();
      phase       = ST_IDLE;
      data_count  = 0;
      running_sum = '0;
      sum_high    = '0;
      power_hold  = '0;
      config_seen = 1'b0;
      check_en    = 1'b0;
      errors      = 0;
      foreach (cfg_bytes[i]) cfg_bytes[i] = '0;
    endfunction

    function void set_check(logic v);
      check_en = v;
    endfunction

    function void parse_byte(logic [7:0] b);
      tcfp_pkg::frame_rec_t rec;
      logic [15:0]          got_sum;
      rec = '0;
      case (phase)
        ST_IDLE: begin
          if (b == tcfp_pkg::CFG_MARK) phase = ST_CFG_MARK2;
          else if (b == tcfp_pkg::DOUT_MARK_A || b == tcfp_pkg::DOUT_MARK_B)
            phase = ST_DOUT_MARK2;
        end
        ST_CFG_MARK2: begin
          if (b == tcfp_pkg::CFG_MARK) begin
            phase       = ST_CFG_DATA;
            data_count  = 0;
            running_sum = '0;
          end else begin
            phase = ST_IDLE;
          end
        end
        ST_CFG_DATA: begin
          cfg_bytes[data_count] = b;
          running_sum = running_sum + 16'(b);
          data_count++;
          if (data_count >= tcfp_pkg::CFG_LEN) phase = ST_CFG_SUM_HI;
        end
        ST_CFG_SUM_HI: begin
          sum_high = b;
          phase    = ST_CFG_SUM_LO;
        end
        ST_CFG_SUM_LO: begin
          got_sum    = {sum_high, b};
          phase      = ST_IDLE;
          data_count = 0;
          if (!(check_en && got_sum != running_sum)) begin
            rec.frame_kind        = tcfp_pkg::KIND_CONFIG;
            rec.accel_gyro_rate   = cfg_bytes[0][1:0];
            rec.analog_power      = cfg_bytes[1][3:0];
            rec.analog_rate       = cfg_bytes[2];
            rec.daq_power_nibbles = {cfg_bytes[6], cfg_bytes[5], cfg_bytes[4], cfg_bytes[3]};
            rec.daq_types_low     = {cfg_bytes[10], cfg_bytes[9], cfg_bytes[8], cfg_bytes[7]};
            rec.daq_types_high    = {cfg_bytes[14], cfg_bytes[13], cfg_bytes[12],
                                     cfg_bytes[11]};
            rec.checksum_ok       = (got_sum == running_sum);
            rec.first_config      = !config_seen;
            config_seen           = 1'b1;
            decoded_frames.push_back(rec);
          end
        end
        ST_DOUT_MARK2: begin
          phase = (b == tcfp_pkg::DOUT_MARK_A || b == tcfp_pkg::DOUT_MARK_B) ?
                  ST_DOUT_POWER : ST_IDLE;
        end
        ST_DOUT_POWER: begin
          power_hold = b;
          phase      = ST_DOUT_STATE;
        end
        default: begin
          phase          = ST_IDLE;
          rec.frame_kind = tcfp_pkg::KIND_DOUT;
          rec.dout_power = power_hold;
          rec.dout_state = b;
          decoded_frames.push_back(rec);
        end
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task match_frame(tcfp_pkg::frame_rec_t got);
      tcfp_pkg::frame_rec_t want;
      if (decoded_frames.size() == 0) begin
        report("frame with nothing pending");
        return;
      end
      want = decoded_frames.pop_front();
      compare("frame_kind", 32'(got.frame_kind), 32'(want.frame_kind));
      compare("accel_gyro_rate", 32'(got.accel_gyro_rate), 32'(want.accel_gyro_rate));
      compare("analog_power", 32'(got.analog_power), 32'(want.analog_power));
      compare("analog_rate", 32'(got.analog_rate), 32'(want.analog_rate));
      compare("daq_power_nibbles", got.daq_power_nibbles, want.daq_power_nibbles);
      compare("daq_types_low", got.daq_types_low, want.daq_types_low);
      compare("daq_types_high", got.daq_types_high, want.daq_types_high);
      compare("dout_power", 32'(got.dout_power), 32'(want.dout_power));
      compare("dout_state", 32'(got.dout_state), 32'(want.dout_state));
      compare("checksum_ok", 32'(got.checksum_ok), 32'(want.checksum_ok));
      compare("first_config", 32'(got.first_config), 32'(want.first_config));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_frame_kind;
  logic [1:0]  out_accel_gyro_rate;
  logic [3:0]  out_analog_power;
  logic [7:0]  out_analog_rate;
  logic [31:0] out_daq_power_nibbles;
  logic [31:0] out_daq_types_low;
  logic [31:0] out_daq_types_high;
  logic [7:0]  out_dout_power;
  logic [7:0]  out_dout_state;
  logic        out_checksum_ok;
  logic        out_first_config;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_checksum_check_enable;

  tcfp_pkg::frame_rec_t out_rec;
  command_frame_scoreboard_t sb = new();
  bit in_idle_en  = 1'b1;
  bit out_idle_en = 1'b1;
  int bytes_sent  = 0;
  int cycle_count = 0;

  assign out_rec = {out_frame_kind, out_accel_gyro_rate, out_analog_power, out_analog_rate,
                    out_daq_power_nibbles, out_daq_types_low, out_daq_types_high,
                    out_dout_power, out_dout_state, out_checksum_ok, out_first_config};

  telemetry_command_frame_parser dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_rx_byte                (in_rx_byte),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_frame_kind            (out_frame_kind),
    .out_accel_gyro_rate       (out_accel_gyro_rate),
    .out_analog_power          (out_analog_power),
    .out_analog_rate           (out_analog_rate),
    .out_daq_power_nibbles     (out_daq_power_nibbles),
    .out_daq_types_low         (out_daq_types_low),
    .out_daq_types_high        (out_daq_types_high),
    .out_dout_power            (out_dout_power),
    .out_dout_state            (out_dout_state),
    .out_checksum_ok           (out_checksum_ok),
    .out_first_config          (out_first_config),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_checksum_check_enable (cfg_checksum_check_enable)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("telemetry_command_frame_parser regression: fail");
      $finish;
    end
  end

  // handshakes are sampled at the edge, before any flop update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_check(cfg_checksum_check_enable);
      if (in_valid && !in_stall) sb.parse_byte(in_rx_byte);
      if (out_valid && !out_stall) sb.match_frame(out_rec);
    end
  end

  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = out_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
    end
  end

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0:       data_byte = ($urandom_range(0, 2) == 0) ? tcfp_pkg::CFG_MARK :
                           ($urandom_range(0, 1) == 0) ? tcfp_pkg::DOUT_MARK_A :
                                                         tcfp_pkg::DOUT_MARK_B;
      1:       data_byte = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
      default: data_byte = 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] dout_mark();
    dout_mark = ($urandom_range(0, 1) == 0) ? tcfp_pkg::DOUT_MARK_A : tcfp_pkg::DOUT_MARK_B;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_config_frame(input cfg_block_t blk, input bit corrupt);
    logic [15:0] sum;
    sum = '0;
    foreach (blk[i]) sum = sum + 16'(blk[i]);
    if (corrupt) sum = sum ^ 16'($urandom_range(1, 65535));
    send_byte(tcfp_pkg::CFG_MARK);
    send_byte(tcfp_pkg::CFG_MARK);
    foreach (blk[i]) send_byte(blk[i]);
    send_byte(sum[15:8]);
    send_byte(sum[7:0]);
  endtask

  task automatic send_dout_frame(input logic [7:0] m1, input logic [7:0] m2,
                                 input logic [7:0] power, input logic [7:0] st);
    send_byte(m1);
    send_byte(m2);
    send_byte(power);
    send_byte(st);
  endtask

  // a dropped frame leaves nothing pending, so allow the pipe to settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.decoded_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_check_enable(input logic v);
    drain_results();
    cfg_valid                 <= 1'b1;
    cfg_checksum_check_enable <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    cfg_block_t blk;
    int         pick;
    int         seg;
    int         seg_end;
    int         base;

    rst_n                     <= 1'b0;
    in_valid                  <= 1'b0;
    in_rx_byte                <= 8'h00;
    cfg_valid                 <= 1'b0;
    cfg_checksum_check_enable <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // idle garbage
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h54);
    // every mark pairing, marks inside the payload
    send_dout_frame(tcfp_pkg::DOUT_MARK_A, tcfp_pkg::DOUT_MARK_A, 8'h00, 8'hFF);
    send_dout_frame(tcfp_pkg::DOUT_MARK_A, tcfp_pkg::DOUT_MARK_B, 8'hFF, 8'h00);
    send_dout_frame(tcfp_pkg::DOUT_MARK_B, tcfp_pkg::DOUT_MARK_A, tcfp_pkg::CFG_MARK,
                    tcfp_pkg::DOUT_MARK_A);
    send_dout_frame(tcfp_pkg::DOUT_MARK_B, tcfp_pkg::DOUT_MARK_B, tcfp_pkg::DOUT_MARK_B,
                    tcfp_pkg::CFG_MARK);
    foreach (blk[i]) blk[i] = 8'hFF;
    send_config_frame(blk, 1'b0);
    foreach (blk[i]) blk[i] = (i % 3 == 0) ? tcfp_pkg::CFG_MARK :
                              (i % 3 == 1) ? tcfp_pkg::DOUT_MARK_A : tcfp_pkg::DOUT_MARK_B;
    send_config_frame(blk, 1'b0);
    // bad sum accepted while checking is off
    foreach (blk[i]) blk[i] = 8'h00;
    send_config_frame(blk, 1'b1);
    // bad second bytes are consumed, not re-examined
    send_byte(tcfp_pkg::CFG_MARK);
    send_byte(8'h00);
    send_byte(tcfp_pkg::CFG_MARK);
    send_byte(tcfp_pkg::DOUT_MARK_A);
    send_byte(tcfp_pkg::DOUT_MARK_B);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(tcfp_pkg::DOUT_MARK_A);
    send_byte(tcfp_pkg::CFG_MARK);
    send_byte(8'h77);

    write_check_enable(1'b1);
    foreach (blk[i]) blk[i] = data_byte();
    send_config_frame(blk, 1'b1);
    foreach (blk[i]) blk[i] = data_byte();
    send_config_frame(blk, 1'b0);

    base = bytes_sent;
    for (seg = 0; seg < 3; seg++) begin
      write_check_enable(seg == 1);
      seg_end = base + (seg + 1) * RANDOM_BYTES / 3;
      while (bytes_sent < seg_end) begin
        if ($urandom_range(0, 7) == 0) begin
          in_idle_en  = ($urandom_range(0, 3) != 0);
          out_idle_en = ($urandom_range(0, 3) != 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          case ($urandom_range(0, 9))
            0:       foreach (blk[i]) blk[i] = 8'h00;
            1:       foreach (blk[i]) blk[i] = 8'hFF;
            default: foreach (blk[i]) blk[i] = data_byte();
          endcase
          send_config_frame(blk, pick >= 40);
        end else if (pick < 85) begin
          send_dout_frame(dout_mark(), dout_mark(), data_byte(), data_byte());
        end else if (pick < 93) begin
          send_byte(($urandom_range(0, 1) == 0) ? tcfp_pkg::CFG_MARK : dout_mark());
          send_byte(data_byte());
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
      end
    end

    drain_results();
    if (sb.decoded_frames.size() != 0)
      sb.report($sformatf("%0d frames never produced", sb.decoded_frames.size()));
    if (sb.errors == 0)
      $display("telemetry_command_frame_parser regression: pass");
    else
      $display("telemetry_command_frame_parser regression: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tcfp_pkg.sv
hw/rtl/tcfp_front.sv
hw/rtl/tcfp_queue.sv
hw/rtl/tcfp_back.sv
hw/rtl/telemetry_command_frame_parser.sv
bench/tb.sv
